// ----- design/pwmfd_pkg.sv -----
// shared types, register indexes and pulse codes of the pwm frame decoder
// no dependencies; every other file refers to it by scoped names
`default_nettype none

package pwmfd_pkg;

   localparam int unsigned TICKS_PER_US_DEF = 10;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int US_BITS        = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIAG_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIAG_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TEMP_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TEMP_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PRES_PERIOD = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PRES_WIDTH  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_LIMIT = 3'd6;

   localparam logic [US_BITS-1:0] FRAME_LIMIT_RESET = 16'hFFFF;
   localparam logic [US_BITS-1:0] US_SATURATED      = 16'hFFFF;

   // pulse kinds, also used as the phase code
   localparam logic [1:0] KIND_DIAG = 2'd0;
   localparam logic [1:0] KIND_TEMP = 2'd1;
   localparam logic [1:0] KIND_PRES = 2'd2;

   // diagnostic classes and their width thresholds in microseconds
   localparam logic [1:0] CLASS_OK        = 2'd0;
   localparam logic [1:0] CLASS_PRES_FAIL = 2'd1;
   localparam logic [1:0] CLASS_TEMP_FAIL = 2'd2;
   localparam logic [1:0] CLASS_HW_FAIL   = 2'd3;

   localparam logic [US_BITS-1:0] DIAG_OK_BELOW        = 16'd280;
   localparam logic [US_BITS-1:0] DIAG_PRES_FAIL_BELOW = 16'd440;
   localparam logic [US_BITS-1:0] DIAG_TEMP_FAIL_BELOW = 16'd600;

   typedef struct packed {
      logic [5:0][CSR_DATA_BITS-1:0] win;
      logic [US_BITS-1:0]            frame_limit;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic               rising;
      logic [US_BITS-1:0] us;
   } conv_type;

   // exclusive window: min in the low half, max in the high half
   function automatic logic in_window(input logic [CSR_DATA_BITS-1:0] win,
                                      input logic [US_BITS-1:0] value);
      in_window = (value > win[15:0]) && (value < win[31:16]);
   endfunction

endpackage

`default_nettype wire

// ----- design/multi_pulse_pwm_frame_decoder.sv -----
// top level of the three-pulse pwm frame decoder
// depends on pwmfd_pkg, pwmfd_csr, pwmfd_timeconv and pwmfd_decode
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  edge_rising, capture_time
//   rsp_      out        rsp_valid/rsp_ready  kind, width, period, class, done, count
//   csr_      in         csr_we               csr_index, csr_wdata
//
// one request per cycle sustained while results are taken; a result passes, once its request is
// accepted, through input register, tick subtract, reciprocal multiply and phase decode
// the tick-to-microsecond multiply sits alone between two pipeline registers
// a falling edge or a rejected pulse gives no result
// reset is synchronous and clears all pipeline valids, state and config registers, not the payload registers
// a stalled result holds the decode stage; earlier stages fill up, then req_ready drops
`default_nettype none

module multi_pulse_pwm_frame_decoder #(
   parameter int unsigned TICKS_PER_US = pwmfd_pkg::TICKS_PER_US_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_edge_rising,
   input  wire logic [31:0] req_capture_time,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_pulse_kind,
   output logic [15:0]      rsp_pulse_width_us,
   output logic [15:0]      rsp_pulse_period_us,
   output logic [1:0]       rsp_diag_class,
   output logic             rsp_frame_done,
   output logic [15:0]      rsp_frame_count,
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   pwmfd_pkg::cfg_type  cfg;    // window and limit registers
   pwmfd_pkg::conv_type conv;   // converted edge time heading to decode
   logic                take_ok; // decode can consume this cycle

   pwmfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // elapsed ticks since the last rising edge, saturated microseconds
   pwmfd_timeconv #(
      .TICKS_PER_US (TICKS_PER_US)
   ) u_timeconv (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_edge_rising  (req_edge_rising),
      .req_capture_time (req_capture_time),
      .take_ok          (take_ok),
      .conv             (conv)
   );

   // sync, phase windows, diagnostic class, frame count, result register
   pwmfd_decode u_decode (
      .clock               (clock),
      .reset               (reset),
      .conv                (conv),
      .cfg                 (cfg),
      .take_ok             (take_ok),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pulse_kind      (rsp_pulse_kind),
      .rsp_pulse_width_us  (rsp_pulse_width_us),
      .rsp_pulse_period_us (rsp_pulse_period_us),
      .rsp_diag_class      (rsp_diag_class),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_frame_count     (rsp_frame_count)
   );

endmodule

`default_nettype wire

// ----- design/pwmfd_csr.sv -----
// configuration registers of the pwm frame decoder
// depends on pwmfd_pkg
`default_nettype none

module pwmfd_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [pwmfd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [pwmfd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output pwmfd_pkg::cfg_type                       cfg
);

   pwmfd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pwmfd_pkg::REG_DIAG_PERIOD: cfg_in.win[0] = csr_wdata;
            pwmfd_pkg::REG_DIAG_WIDTH:  cfg_in.win[1] = csr_wdata;
            pwmfd_pkg::REG_TEMP_PERIOD: cfg_in.win[2] = csr_wdata;
            pwmfd_pkg::REG_TEMP_WIDTH:  cfg_in.win[3] = csr_wdata;
            pwmfd_pkg::REG_PRES_PERIOD: cfg_in.win[4] = csr_wdata;
            pwmfd_pkg::REG_PRES_WIDTH:  cfg_in.win[5] = csr_wdata;
            pwmfd_pkg::REG_FRAME_LIMIT: cfg_in.frame_limit = csr_wdata[15:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win         <= '0;
         cfg_ff.frame_limit <= pwmfd_pkg::FRAME_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/pwmfd_timeconv.sv -----
// input register, elapsed-time subtract and tick-to-microsecond conversion
// depends on pwmfd_pkg; constant division done as a reciprocal multiply
`default_nettype none

module pwmfd_timeconv #(
   parameter int unsigned TICKS_PER_US = pwmfd_pkg::TICKS_PER_US_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_edge_rising,
   input  wire logic [31:0] req_capture_time,
   input  wire logic        take_ok,
   output pwmfd_pkg::conv_type conv
);

   localparam int LOG_T     = $clog2(TICKS_PER_US);
   localparam int TICK_BITS = pwmfd_pkg::US_BITS + LOG_T;
   localparam int SHIFT     = TICK_BITS + LOG_T;
   localparam int RECIP_BITS = TICK_BITS + 2;
   localparam int PROD_BITS = TICK_BITS + RECIP_BITS;
   localparam logic [31:0] SAT_TICKS = 32'(64'(TICKS_PER_US) << pwmfd_pkg::US_BITS);
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(
      ((64'd1 << SHIFT) + 64'(TICKS_PER_US) - 64'd1) / 64'(TICKS_PER_US));

   // stage 1: input register
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_rising_ff;
   logic [31:0] s1_time_ff;
   logic [31:0] last_rise_ff, last_rise_in;
   // stage 2: elapsed ticks
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_rising_ff;
   logic                 s2_sat_ff;
   logic [TICK_BITS-1:0] s2_ticks_ff;
   // stage 3: microseconds
   logic                         s3_valid_ff, s3_valid_in;
   logic                         s3_rising_ff;
   logic [pwmfd_pkg::US_BITS-1:0] s3_us_ff;

   logic                 ld1, ld2, ld3;
   logic [31:0]          delta;
   logic [PROD_BITS-1:0] prod;
   logic [pwmfd_pkg::US_BITS-1:0] us_value;

   assign ld3 = !s3_valid_ff || take_ok;
   assign ld2 = !s2_valid_ff || ld3;
   assign ld1 = !s1_valid_ff || ld2;
   assign req_ready = ld1;

   assign delta = s1_time_ff - last_rise_ff;
   assign prod  = PROD_BITS'(s2_ticks_ff) * PROD_BITS'(RECIP);
   assign us_value = s2_sat_ff ? pwmfd_pkg::US_SATURATED : prod[SHIFT +: pwmfd_pkg::US_BITS];

   always_comb begin
      s1_valid_in  = ld1 ? req_valid : s1_valid_ff;
      s2_valid_in  = ld2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = ld3 ? s2_valid_ff : s3_valid_ff;
      last_rise_in = last_rise_ff;
      if (s1_valid_ff && ld2 && s1_rising_ff) begin
         last_rise_in = s1_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         last_rise_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         last_rise_ff <= last_rise_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_rising_ff <= req_edge_rising;
         s1_time_ff   <= req_capture_time;
      end
      if (ld2) begin
         s2_rising_ff <= s1_rising_ff;
         s2_sat_ff    <= (delta >= SAT_TICKS);
         s2_ticks_ff  <= delta[TICK_BITS-1:0];
      end
      if (ld3) begin
         s3_rising_ff <= s2_rising_ff;
         s3_us_ff     <= us_value;
      end
   end

   assign conv.valid  = s3_valid_ff;
   assign conv.rising = s3_rising_ff;
   assign conv.us     = s3_us_ff;

endmodule

`default_nettype wire

// ----- design/pwmfd_decode.sv -----
// phase tracking, window checks, frame counter and result register
// depends on pwmfd_pkg
`default_nettype none

module pwmfd_decode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pwmfd_pkg::conv_type  conv,
   input  wire pwmfd_pkg::cfg_type   cfg,
   output logic                      take_ok,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_pulse_kind,
   output logic [15:0]               rsp_pulse_width_us,
   output logic [15:0]               rsp_pulse_period_us,
   output logic [1:0]                rsp_diag_class,
   output logic                      rsp_frame_done,
   output logic [15:0]               rsp_frame_count
);

   logic [1:0]  phase_ff, phase_in;
   logic        synced_ff, synced_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff;
   logic [15:0] out_width_ff, out_period_ff, out_count_ff;
   logic [1:0]  class_ff;
   logic        done_ff;

   logic        fire, emit, sync_hit, ok;
   logic [1:0]  ph, dclass;
   logic [31:0] per_win, wid_win;
   logic [16:0] count_inc;

   assign take_ok = !rsp_valid_ff || rsp_ready;
   assign fire    = conv.valid && take_ok;

   always_comb begin
      sync_hit = pwmfd_pkg::in_window(cfg.win[0], conv.us);
      ph       = sync_hit ? pwmfd_pkg::KIND_DIAG : phase_ff;
      ok       = 1'b0;
      per_win  = '0;
      wid_win  = '0;
      unique case (ph)
         pwmfd_pkg::KIND_DIAG: begin
            per_win = cfg.win[0];
            wid_win = cfg.win[1];
            ok      = 1'b1;
         end
         pwmfd_pkg::KIND_TEMP: begin
            per_win = cfg.win[2];
            wid_win = cfg.win[3];
            ok      = 1'b1;
         end
         pwmfd_pkg::KIND_PRES: begin
            per_win = cfg.win[4];
            wid_win = cfg.win[5];
            ok      = 1'b1;
         end
         default: ok = 1'b0;  // stray phase matches no window
      endcase
      ok = ok && pwmfd_pkg::in_window(per_win, conv.us)
              && pwmfd_pkg::in_window(wid_win, width_ff);

      priority if (width_ff < pwmfd_pkg::DIAG_OK_BELOW)        dclass = pwmfd_pkg::CLASS_OK;
      else if (width_ff < pwmfd_pkg::DIAG_PRES_FAIL_BELOW)     dclass = pwmfd_pkg::CLASS_PRES_FAIL;
      else if (width_ff < pwmfd_pkg::DIAG_TEMP_FAIL_BELOW)     dclass = pwmfd_pkg::CLASS_TEMP_FAIL;
      else                                                     dclass = pwmfd_pkg::CLASS_HW_FAIL;
      if (ph != pwmfd_pkg::KIND_DIAG) begin
         dclass = pwmfd_pkg::CLASS_OK;
      end

      count_inc = {1'b0, count_ff} + 17'd1;

      phase_in  = phase_ff;
      synced_in = synced_ff;
      width_in  = width_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      if (fire) begin
         if (!conv.rising) begin
            width_in = conv.us;
         end else if (synced_ff || sync_hit) begin
            synced_in = 1'b1;
            emit      = ok;
            if (ok && ph == pwmfd_pkg::KIND_PRES) begin
               count_in = (count_inc > {1'b0, cfg.frame_limit}) ? 16'd0 : count_inc[15:0];
            end
            unique case (ph)
               pwmfd_pkg::KIND_DIAG: phase_in = pwmfd_pkg::KIND_TEMP;
               pwmfd_pkg::KIND_TEMP: phase_in = pwmfd_pkg::KIND_PRES;
               pwmfd_pkg::KIND_PRES: phase_in = pwmfd_pkg::KIND_DIAG;
               default:              phase_in = pwmfd_pkg::KIND_TEMP;
            endcase
         end
      end

      rsp_valid_in = fire ? emit : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pwmfd_pkg::KIND_DIAG;
         synced_ff    <= 1'b0;
         width_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         synced_ff    <= synced_in;
         width_ff     <= width_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         kind_ff       <= ph;
         out_width_ff  <= width_ff;
         out_period_ff <= conv.us;
         class_ff      <= dclass;
         done_ff       <= (ph == pwmfd_pkg::KIND_PRES);
         out_count_ff  <= count_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pulse_kind      = kind_ff;
   assign rsp_pulse_width_us  = out_width_ff;
   assign rsp_pulse_period_us = out_period_ff;
   assign rsp_diag_class      = class_ff;
   assign rsp_frame_done      = done_ff;
   assign rsp_frame_count     = out_count_ff;

endmodule

`default_nettype wire

// ----- design/pwmfd_checker.sv -----
// port-level checks of the pwm frame decoder, bound to the top level
// depends on pwmfd_pkg and multi_pulse_pwm_frame_decoder
`default_nettype none

module pwmfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_edge_rising,
   input wire logic [31:0] req_capture_time,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_pulse_kind,
   input wire logic [15:0] rsp_pulse_width_us,
   input wire logic [15:0] rsp_pulse_period_us,
   input wire logic [1:0]  rsp_diag_class,
   input wire logic        rsp_frame_done,
   input wire logic [15:0] rsp_frame_count,
   input wire logic        csr_we,
   input wire logic [2:0]  csr_index,
   input wire logic [31:0] csr_wdata
);

   // a stalled result keeps its kind, width, period and count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_kind)
         && $stable(rsp_pulse_width_us) && $stable(rsp_pulse_period_us)
         && $stable(rsp_frame_count))
      else $error("result changed while stalled");

   // frame done exactly on pressure pulses
   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_done == (rsp_pulse_kind == pwmfd_pkg::KIND_PRES)))
      else $error("frame done does not match pulse kind");

   // class only on diagnostic pulses
   a_class_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pulse_kind != pwmfd_pkg::KIND_DIAG
         |-> rsp_diag_class == pwmfd_pkg::CLASS_OK)
      else $error("class set on a non-diagnostic pulse");

   // no result comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind multi_pulse_pwm_frame_decoder pwmfd_checker u_pwmfd_checker (.*);

`default_nettype wire

// ----- tb/sv/multi_pulse_pwm_frame_decoder_tb.sv -----
// self-checking testbench of the three-pulse pwm frame decoder
// depends on pwmfd_pkg and multi_pulse_pwm_frame_decoder with pwmfd_csr, pwmfd_timeconv and pwmfd_decode

module multi_pulse_pwm_frame_decoder_tb;

   localparam int unsigned TICKS         = pwmfd_pkg::TICKS_PER_US_DEF;
   localparam int          SETTLE_CYCLES = 12;   // pipeline is four deep, leave margin
   localparam int          STALL_LIMIT   = 2000; // cycles with no handshake at all
   localparam logic [2:0]  REG_UNUSED    = 3'd7; // index with no register behind it

   // register settings the random phases run under
   typedef enum logic [1:0] {
      CFG_NOMINAL,
      CFG_WIDE_OPEN,
      CFG_CLOSED,
      CFG_SCRAMBLED
   } cfg_profile_type;

   // one decoded pulse as it leaves the block
   typedef struct {
      logic [1:0]  kind;
      logic [15:0] width_us;
      logic [15:0] period;
      logic [1:0]  dclass;
      logic        done;
      logic [15:0] count;
   } pulse_result_type;

   // decoder state mirror plus the queue of pulses still to come out
   class pulse_scoreboard;
      logic [31:0]      win [6];
      logic [15:0]      frame_limit;
      logic [31:0]      last_rise;
      logic [15:0]      last_width;
      logic [1:0]       phase;
      bit               locked;
      logic [15:0]      frames;
      pulse_result_type pulse_q [$];
      int               mismatches;
      int               checked;
      int               frame_ends;
      int               per_kind [3];

      function new();
         foreach (win[i]) win[i] = '0;
         frame_limit = pwmfd_pkg::FRAME_LIMIT_RESET;
         last_rise   = '0;
         last_width  = '0;
         phase       = pwmfd_pkg::KIND_DIAG;
         locked      = 1'b0;
         frames      = '0;
         mismatches  = 0;
         checked     = 0;
         frame_ends  = 0;
         foreach (per_kind[i]) per_kind[i] = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         if (idx <= pwmfd_pkg::REG_PRES_WIDTH)
            win[idx] = data;
         else if (idx == pwmfd_pkg::REG_FRAME_LIMIT)
            frame_limit = data[15:0];
      endfunction

      function int pending();
         return pulse_q.size();
      endfunction

      // ticks since the last rising edge, truncated to us and clipped
      function logic [15:0] to_us(logic [31:0] stamp);
         logic [31:0] q;
         q = (stamp - last_rise) / TICKS;
         return (q > 32'(pwmfd_pkg::US_SATURATED)) ? pwmfd_pkg::US_SATURATED : q[15:0];
      endfunction

      function bit between(logic [31:0] w, logic [15:0] v);
         return (v > w[15:0]) && (v < w[31:16]);
      endfunction

      function logic [1:0] classify(logic [15:0] w);
         if (w < pwmfd_pkg::DIAG_OK_BELOW)        return pwmfd_pkg::CLASS_OK;
         if (w < pwmfd_pkg::DIAG_PRES_FAIL_BELOW) return pwmfd_pkg::CLASS_PRES_FAIL;
         if (w < pwmfd_pkg::DIAG_TEMP_FAIL_BELOW) return pwmfd_pkg::CLASS_TEMP_FAIL;
         return pwmfd_pkg::CLASS_HW_FAIL;
      endfunction

      function void note_request(logic rising, logic [31:0] stamp);
         logic [15:0]      span;
         logic [31:0]      bump;
         pulse_result_type exp;
         span = to_us(stamp);
         if (!rising) begin
            last_width = span;
            return;
         end
         if (between(win[pwmfd_pkg::REG_DIAG_PERIOD], span)) begin
            phase  = pwmfd_pkg::KIND_DIAG;
            locked = 1'b1;
         end
         if (locked) begin
            if (phase <= pwmfd_pkg::KIND_PRES && between(win[{phase, 1'b0}], span)
                && between(win[{phase, 1'b1}], last_width)) begin
               exp.kind     = phase;
               exp.width_us = last_width;
               exp.period   = span;
               exp.dclass   = (phase == pwmfd_pkg::KIND_DIAG) ? classify(last_width)
                                                              : pwmfd_pkg::CLASS_OK;
               exp.done     = 1'b0;
               if (phase == pwmfd_pkg::KIND_PRES) begin
                  bump   = 32'(frames) + 32'd1;
                  frames = (bump > 32'(frame_limit)) ? 16'd0 : bump[15:0];
                  exp.done = 1'b1;
                  frame_ends++;
               end
               exp.count = frames;
               pulse_q.push_back(exp);
            end
            phase = (phase == pwmfd_pkg::KIND_PRES) ? pwmfd_pkg::KIND_DIAG :
                    (phase == pwmfd_pkg::KIND_TEMP) ? pwmfd_pkg::KIND_PRES :
                                                      pwmfd_pkg::KIND_TEMP;
         end
         last_rise = stamp;
      endfunction

      function string describe(pulse_result_type r);
         return $sformatf("kind %0d width %0d period %0d class %0d done %0d count %0d",
                          r.kind, r.width_us, r.period, r.dclass, r.done, r.count);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_result(pulse_result_type got);
         pulse_result_type exp;
         if (pulse_q.size() == 0) begin
            flag({"pulse out with none pending: ", describe(got)});
            return;
         end
         exp = pulse_q.pop_front();
         checked++;
         if (exp.kind <= pwmfd_pkg::KIND_PRES) per_kind[exp.kind]++;
         if (got.kind !== exp.kind || got.width_us !== exp.width_us
             || got.period !== exp.period || got.dclass !== exp.dclass
             || got.done !== exp.done || got.count !== exp.count)
            flag({"pulse mismatch: got ", describe(got), " / expected ", describe(exp)});
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // block inputs, all known from time zero
   logic        req_valid        = 1'b0;
   logic        req_edge_rising  = 1'b0;
   logic [31:0] req_capture_time = '0;
   logic        rsp_ready        = 1'b0;
   logic        csr_we           = 1'b0;
   logic [2:0]  csr_index        = '0;
   logic [31:0] csr_wdata        = '0;

   // block outputs
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_pulse_kind;
   logic [15:0] rsp_pulse_width_us;
   logic [15:0] rsp_pulse_period_us;
   logic [1:0]  rsp_diag_class;
   logic        rsp_frame_done;
   logic [15:0] rsp_frame_count;

   multi_pulse_pwm_frame_decoder #(
      .TICKS_PER_US (TICKS)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_edge_rising     (req_edge_rising),
      .req_capture_time    (req_capture_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pulse_kind      (rsp_pulse_kind),
      .rsp_pulse_width_us  (rsp_pulse_width_us),
      .rsp_pulse_period_us (rsp_pulse_period_us),
      .rsp_diag_class      (rsp_diag_class),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_frame_count     (rsp_frame_count),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   pulse_scoreboard sb = new();

   // testbench-side bookkeeping
   logic [31:0] cur_win [6];         // windows as last written, steers the pulse generator
   logic [31:0] last_rise_sent = '0; // capture time of the last rising-edge request
   int          reqs_sent      = 0;
   int          phases_run     = 0;
   bit          req_calm       = 1'b0; // when set the sender runs back to back
   bit          rsp_calm       = 1'b0; // when set the receiver never stalls
   int          stall_cycles   = 0;

   // idle cycles before the next request or result
   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   // a value strictly inside the window most of the time, anything up to span otherwise
   function automatic int unsigned pick(logic [31:0] w, int unsigned span);
      if (w[31:16] > w[15:0] + 1 && $urandom_range(0, 9) != 0)
         return $urandom_range(w[15:0] + 1, w[31:16] - 1);
      return $urandom_range(0, span);
   endfunction

   function automatic logic [31:0] window_for(cfg_profile_type profile, logic [2:0] idx);
      case (profile)
         CFG_WIDE_OPEN: return 32'hFFFF_0000; // 0 < v < 65535
         CFG_CLOSED:    return 32'hFFFF_FFFF; // min equals max, nothing passes
         CFG_SCRAMBLED: return $urandom();
         default: begin
            // disjoint period windows so only a diag-length period resyncs
            case (idx)
               pwmfd_pkg::REG_DIAG_PERIOD: return {16'd1100, 16'd900};
               pwmfd_pkg::REG_DIAG_WIDTH:  return {16'd1000, 16'd10};
               pwmfd_pkg::REG_TEMP_PERIOD: return {16'd1500, 16'd1300};
               pwmfd_pkg::REG_TEMP_WIDTH:  return {16'd1200, 16'd100};
               pwmfd_pkg::REG_PRES_PERIOD: return {16'd1900, 16'd1700};
               pwmfd_pkg::REG_PRES_WIDTH:  return {16'd1600, 16'd200};
               default:                    return '0;
            endcase
         end
      endcase
   endfunction

   // one request: optional idle cycles, then hold valid until accepted
   task automatic send_req(input logic rising, input logic [31:0] stamp);
      int gap;
      gap = draw_gap(req_calm);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_edge_rising  <= rising;
      req_capture_time <= stamp;
      do @(posedge clock); while (!req_ready);
      sb.note_request(rising, stamp);
      reqs_sent++;
      if (rising) last_rise_sent = stamp;
   endtask

   // falling edge w us after the last rise, next rise p us after it, sub-us jitter
   task automatic send_pulse(input int unsigned w, input int unsigned p,
                             input bit skip_fall = 1'b0);
      logic [31:0] base;
      base = last_rise_sent;
      if (!skip_fall)
         send_req(1'b0, base + 32'(w * TICKS) + $urandom_range(0, TICKS - 1));
      send_req(1'b1, base + 32'(p * TICKS) + $urandom_range(0, TICKS - 1));
   endtask

   // pulse shaped for the given phase; now and then the falling edge goes missing
   task automatic gen_pulse(input logic [1:0] kind);
      int unsigned p;
      int unsigned w;
      p = pick(cur_win[{kind, 1'b0}], 2500);
      w = pick(cur_win[{kind, 1'b1}], p);
      send_pulse(w, p, $urandom_range(0, 19) == 0);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      if (idx <= pwmfd_pkg::REG_PRES_WIDTH) cur_win[idx] = data;
   endtask

   task automatic load_settings(input cfg_profile_type profile, input logic [15:0] lim,
                                input bit with_limit);
      csr_write(pwmfd_pkg::REG_DIAG_PERIOD, window_for(profile, pwmfd_pkg::REG_DIAG_PERIOD));
      csr_write(pwmfd_pkg::REG_DIAG_WIDTH,  window_for(profile, pwmfd_pkg::REG_DIAG_WIDTH));
      csr_write(pwmfd_pkg::REG_TEMP_PERIOD, window_for(profile, pwmfd_pkg::REG_TEMP_PERIOD));
      csr_write(pwmfd_pkg::REG_TEMP_WIDTH,  window_for(profile, pwmfd_pkg::REG_TEMP_WIDTH));
      csr_write(pwmfd_pkg::REG_PRES_PERIOD, window_for(profile, pwmfd_pkg::REG_PRES_PERIOD));
      csr_write(pwmfd_pkg::REG_PRES_WIDTH,  window_for(profile, pwmfd_pkg::REG_PRES_WIDTH));
      // junk in the upper half must be dropped by the 16-bit limit register
      if (with_limit) csr_write(pwmfd_pkg::REG_FRAME_LIMIT, {16'($urandom()), lim});
      // a write to the unused index has to change nothing
      csr_write(REG_UNUSED, $urandom());
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // sender holds off until every pending pulse has come out
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // falling edges and rejected pulses leave nothing pending but may still be in flight
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register setting followed by mostly well-formed frames with random content
   task automatic run_phase(input cfg_profile_type profile, input logic [15:0] lim,
                            input int count);
      int stop_at;
      int sel;
      settle();
      load_settings(profile, lim, 1'b1);
      phases_run++;
      stop_at = reqs_sent + count;
      while (reqs_sent < stop_at) begin
         sel = $urandom_range(0, 19);
         if (sel < 15) begin
            // diag, temp, pressure in order
            gen_pulse(pwmfd_pkg::KIND_DIAG);
            gen_pulse(pwmfd_pkg::KIND_TEMP);
            gen_pulse(pwmfd_pkg::KIND_PRES);
         end else if (sel < 17) begin
            // random edges at random times
            repeat ($urandom_range(1, 3))
               send_req(1'($urandom_range(0, 1)), $urandom());
         end else if (sel == 17) begin
            // long gaps, both measurements clip at 65535 us
            send_req(1'b0, last_rise_sent + 32'd655360 + $urandom_range(0, 32'h7FFF_FFFF));
            send_req(1'b1, last_rise_sent + 32'd655360 + $urandom_range(0, 32'h7FFF_FFFF));
         end else begin
            // pulse out of order
            gen_pulse(2'($urandom_range(0, 2)));
         end
         if ($urandom_range(0, 7) == 0) req_calm = !req_calm;
         if ($urandom_range(0, 7) == 0) rsp_calm = !rsp_calm;
         if ($urandom_range(0, 49) == 0) drain();
      end
   endtask

   // result side: random stalls, ready held while waiting for a pulse
   initial begin : result_side
      pulse_result_type got;
      int               gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap(rsp_calm);
         repeat (gap) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.kind     = rsp_pulse_kind;
         got.width_us = rsp_pulse_width_us;
         got.period   = rsp_pulse_period_us;
         got.dclass   = rsp_diag_class;
         got.done     = rsp_frame_done;
         got.count    = rsp_frame_count;
         sb.check_result(got);
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", stall_cycles);
         $display("[multi_pulse_pwm_frame_decoder] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      foreach (cur_win[i]) cur_win[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: all windows closed, never synced, nothing comes out
      send_req(1'b1, 32'h0000_0000);
      send_req(1'b0, 32'h0000_1234);
      send_req(1'b1, $urandom());
      settle();

      // nominal windows, frame limit left at its reset value
      load_settings(CFG_NOMINAL, 16'd0, 1'b0);

      // directed: capture time at both extremes and wrapping through zero
      send_req(1'b1, 32'hFFFF_FFFF);   // period unlikely in window, still unsynced
      send_req(1'b0, 32'h0000_0000);   // one tick high, width 0 us
      send_req(1'b1, 32'd9_999);       // 1000 us period syncs, width 0 rejected
      send_pulse(500, 1400);           // temperature
      send_pulse(800, 1800);           // pressure, first frame
      // diagnostic width on each side of the class thresholds
      send_pulse(100, 1000);
      send_pulse(280, 1000);
      send_pulse(440, 1000);
      send_pulse(600, 1000);
      // window limits are exclusive
      send_pulse(500, 1300);           // temperature period at min, rejected
      send_pulse(1600, 1800);          // pressure width at max, rejected
      send_pulse(999, 1099);           // diagnostic just inside, hardware class
      send_pulse(101, 1499);           // temperature just inside
      // clipped width and period, pressure phase rejects
      send_req(1'b0, last_rise_sent + 32'd700_000);
      send_req(1'b1, last_rise_sent + 32'hF000_0000);

      // random phases, limit extremes and wrap included
      run_phase(CFG_NOMINAL,   16'd3,                           300);
      run_phase(CFG_WIDE_OPEN, 16'd7,                           200);
      run_phase(CFG_NOMINAL,   16'hFFFF,                        350);
      run_phase(CFG_SCRAMBLED, 16'($urandom()),                 200);
      run_phase(CFG_CLOSED,    16'd1,                           100);
      run_phase(CFG_NOMINAL,   16'd0,                           300);
      run_phase(CFG_NOMINAL,   16'($urandom_range(1, 40)),      275);

      // wait out the pipeline, then anything still pending is lost
      settle();
      if (sb.pending() != 0)
         sb.flag($sformatf("%0d expected pulses never came out", sb.pending()));

      $display("run covered %0d edge requests under %0d register settings",
               reqs_sent, phases_run + 1);
      $display("pulses checked: %0d diagnostic, %0d temperature, %0d pressure, %0d frames",
               sb.per_kind[pwmfd_pkg::KIND_DIAG], sb.per_kind[pwmfd_pkg::KIND_TEMP],
               sb.per_kind[pwmfd_pkg::KIND_PRES], sb.frame_ends);
      if (sb.mismatches == 0)
         $display("[multi_pulse_pwm_frame_decoder] OK");
      else
         $display("[multi_pulse_pwm_frame_decoder] ERROR");
      $finish;
   end

endmodule
